// ===== rtl/oasb_pkg.sv =====
// Shared constants, op codes and controller types for the overlap-add sample buffer.
package oasb_pkg;

	localparam int DEPTH   = 2048;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PTR_W   = ADDR_W + 1;
	localparam int STORE_W = 16;
	localparam int LEVEL_W = 12;
	localparam int OP_W    = 3;
	localparam int POS_W   = 11;
	localparam int ADV_W   = 12;

	localparam logic signed [STORE_W:0] SAT_MAX = (STORE_W+1)'((1 << (STORE_W - 1)) - 1);
	localparam logic signed [STORE_W:0] SAT_MIN = -SAT_MAX - (STORE_W+1)'(1);

	localparam logic [OP_W-1:0] OP_ACC     = 3'd0;
	localparam logic [OP_W-1:0] OP_ADV     = 3'd1;
	localparam logic [OP_W-1:0] OP_CONSUME = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic sweep;
	} cmd_t;

	typedef struct packed {
		logic sweep_busy;
		logic out_free;
		logic is_clear;
	} sts_t;

endpackage

// ===== rtl/overlap_add_sample_buffer_top.sv =====
// Top level of the overlap-add sample buffer: controller plus datapath.
//
// Ring buffer of 2048 Q1.15 samples for overlap-add audio. Each input beat
// carries an op: accumulate (saturating add at write pointer + position),
// advance (move write pointer), consume (read and zero the sample at the read
// pointer), peek (read at read pointer + position) or clear. Every input beat
// yields exactly one output beat with the sample read and fill, hunger,
// satisfied, space-ahead and overflow status after the op. The accept cycle
// issues the single memory read; the execute state then does the add/zero
// write-back, moves the pointers and loads the output register. A new item
// is not accepted until that is done, and execution waits while the previous
// result is still stalled in the output register. After reset the block zeroes
// the whole memory (all 2048 addresses) with in_stall high. A clear op zeroes
// only the occupied window, again with in_stall high. preload_level is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. It resets to 256.
module overlap_add_sample_buffer_top import oasb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// config
	input  logic                      cfg_wr_en,
	input  logic [LEVEL_W-1:0]        cfg_wr_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [OP_W-1:0]           op,
	input  logic signed [STORE_W-1:0] sample_in,
	input  logic [POS_W-1:0]          position,
	input  logic [ADV_W-1:0]          advance,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [STORE_W-1:0] sample_out,
	output logic [LEVEL_W-1:0]        fill_level,
	output logic [LEVEL_W-1:0]        hunger,
	output logic                      satisfied,
	output logic [LEVEL_W-1:0]        space_ahead,
	output logic                      overflow
);

	cmd_t cmd;
	sts_t sts;

	oasb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	oasb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.sample_in   (sample_in),
		.position    (position),
		.advance     (advance),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.sample_out  (sample_out),
		.fill_level  (fill_level),
		.hunger      (hunger),
		.satisfied   (satisfied),
		.space_ahead (space_ahead),
		.overflow    (overflow)
	);

endmodule

// ===== rtl/oasb_ctrl.sv =====
// Controller state machine: clearing sweep, idle/accept, execute/commit.
module oasb_ctrl import oasb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  sts_t   sts,
	output logic   in_stall,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (!sts.sweep_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.out_free) state_d = sts.is_clear ? ST_SWEEP : ST_IDLE;
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		cmd.sweep  = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/oasb_datapath.sv =====
// Datapath: pointers, sample memory, clearing sweep, status math and result register.
module oasb_datapath import oasb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [OP_W-1:0]           op,
	input  logic signed [STORE_W-1:0] sample_in,
	input  logic [POS_W-1:0]          position,
	input  logic [ADV_W-1:0]          advance,
	input  logic                      cfg_wr_en,
	input  logic [LEVEL_W-1:0]        cfg_wr_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic signed [STORE_W-1:0] sample_out,
	output logic [LEVEL_W-1:0]        fill_level,
	output logic [LEVEL_W-1:0]        hunger,
	output logic                      satisfied,
	output logic [LEVEL_W-1:0]        space_ahead,
	output logic                      overflow
);

	// control state
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q, used_q;
	logic [LEVEL_W-1:0] preload_q;
	logic [ADDR_W-1:0]  sw_addr_q;
	logic [PTR_W-1:0]   sw_cnt_q;
	logic               out_valid_q;

	// item payload held through execute
	logic [OP_W-1:0]           op_q;
	logic signed [STORE_W-1:0] sample_q;
	logic [POS_W-1:0]          pos_q;
	logic [ADV_W-1:0]          adv_q;
	logic [ADDR_W-1:0]         addr_q;
	logic signed [STORE_W-1:0] rdata_q;

	logic signed [STORE_W-1:0] mem_q [DEPTH];

	logic [ADDR_W-1:0]         rd_addr;
	logic [PTR_W-1:0]          fill_cur;
	logic [PTR_W:0]            acc_t;
	logic [PTR_W:0]            acc_t1;
	logic [PTR_W:0]            adv_sum;
	logic signed [STORE_W:0]   sum;
	logic signed [STORE_W-1:0] sat_val;
	logic [PTR_W-1:0]          rd_ptr_n, wr_ptr_n, used_n, fill_n;
	logic signed [STORE_W-1:0] rd_val;
	logic                      ovf;
	logic                      commit_we;
	logic signed [STORE_W-1:0] commit_wdata;
	logic                      sw_busy;
	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	logic signed [STORE_W-1:0] mem_wdata;
	logic [LEVEL_W-1:0]        fill_lv;
	logic                      sat_n;

	assign sw_busy = (sw_cnt_q != '0);

	assign sts.sweep_busy = sw_busy;
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.is_clear   = (op_q == OP_CLEAR);

	// read address chosen at accept
	always_comb begin
		case (op)
			OP_ACC:  rd_addr = wr_ptr_q[ADDR_W-1:0] + ADDR_W'(position);
			OP_PEEK: rd_addr = rd_ptr_q[ADDR_W-1:0] + ADDR_W'(position);
			default: rd_addr = rd_ptr_q[ADDR_W-1:0];
		endcase
	end

	assign fill_cur = wr_ptr_q - rd_ptr_q;
	assign acc_t    = {1'b0, fill_cur} + (PTR_W+1)'(pos_q);
	assign acc_t1   = acc_t + (PTR_W+1)'(1);
	assign adv_sum  = {1'b0, fill_cur} + (PTR_W+1)'(adv_q);
	assign sum      = (STORE_W+1)'(rdata_q) + (STORE_W+1)'(sample_q);

	always_comb begin
		if (sum > SAT_MAX)      sat_val = SAT_MAX[STORE_W-1:0];
		else if (sum < SAT_MIN) sat_val = SAT_MIN[STORE_W-1:0];
		else                    sat_val = sum[STORE_W-1:0];
	end

	// next pointer state and result of the held item
	always_comb begin
		rd_ptr_n     = rd_ptr_q;
		wr_ptr_n     = wr_ptr_q;
		used_n       = used_q;
		rd_val       = '0;
		ovf          = 1'b0;
		commit_we    = 1'b0;
		commit_wdata = '0;
		case (op_q)
			OP_ACC: begin
				if (acc_t >= (PTR_W+1)'(DEPTH)) begin
					ovf = 1'b1;
				end else begin
					commit_we    = 1'b1;
					commit_wdata = sat_val;
					if (acc_t1 > (PTR_W+1)'(used_q)) used_n = acc_t1[PTR_W-1:0];
				end
			end
			OP_ADV: begin
				if (adv_sum > (PTR_W+1)'(DEPTH)) ovf = 1'b1;
				else wr_ptr_n = wr_ptr_q + PTR_W'(adv_q);
			end
			OP_CONSUME: begin
				if (used_q != '0) begin
					rd_val    = rdata_q;
					commit_we = 1'b1;
					rd_ptr_n  = rd_ptr_q + PTR_W'(1);
					used_n    = used_q - PTR_W'(1);
					if (fill_cur == '0) wr_ptr_n = rd_ptr_q + PTR_W'(1);
				end
			end
			OP_PEEK: begin
				if (PTR_W'(pos_q) < used_q) rd_val = rdata_q;
			end
			OP_CLEAR: begin
				rd_ptr_n = '0;
				wr_ptr_n = '0;
				used_n   = '0;
			end
			default: ;
		endcase
	end

	assign fill_n  = wr_ptr_n - rd_ptr_n;
	assign fill_lv = LEVEL_W'(fill_n);
	assign sat_n   = (fill_lv >= preload_q);

	assign mem_we    = (cmd.commit && commit_we) || (cmd.sweep && sw_busy);
	assign mem_waddr = cmd.sweep ? sw_addr_q : addr_q;
	assign mem_wdata = cmd.sweep ? '0 : commit_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)     mem_q[mem_waddr] <= mem_wdata;
		if (cmd.accept) rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			used_q      <= '0;
			preload_q   <= LEVEL_W'(256);
			sw_addr_q   <= '0;
			sw_cnt_q    <= PTR_W'(DEPTH);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) preload_q <= cfg_wr_data;
			if (cmd.commit) begin
				rd_ptr_q <= rd_ptr_n;
				wr_ptr_q <= wr_ptr_n;
				used_q   <= used_n;
			end
			if (cmd.commit && (op_q == OP_CLEAR)) begin
				// only the live window can hold nonzero samples
				sw_addr_q <= rd_ptr_q[ADDR_W-1:0];
				sw_cnt_q  <= used_q;
			end else if (cmd.sweep && sw_busy) begin
				sw_addr_q <= sw_addr_q + ADDR_W'(1);
				sw_cnt_q  <= sw_cnt_q - PTR_W'(1);
			end
			if (cmd.commit)      out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= op;
			sample_q <= sample_in;
			pos_q    <= position;
			adv_q    <= advance;
			addr_q   <= rd_addr;
		end
		if (cmd.commit) begin
			sample_out  <= rd_val;
			fill_level  <= fill_lv;
			hunger      <= sat_n ? '0 : preload_q - fill_lv;
			satisfied   <= sat_n;
			space_ahead <= (used_n > fill_n) ? LEVEL_W'(used_n - fill_n) : '0;
			overflow    <= ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/oasb_checker.sv =====
// Port-level checker for the overlap-add sample buffer, bound to the top level.
module oasb_checker import oasb_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [STORE_W-1:0] sample_out,
	input logic [LEVEL_W-1:0]        fill_level,
	input logic [LEVEL_W-1:0]        hunger,
	input logic                      satisfied,
	input logic                      overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_sat_hunger: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (satisfied == (hunger == '0)))
		else $error("satisfied and hunger disagree");

	a_ovf_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> sample_out == '0)
		else $error("dropped write returned a sample");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_level <= LEVEL_W'(DEPTH))
		else $error("fill level beyond capacity");

endmodule

bind overlap_add_sample_buffer_top oasb_checker u_oasb_checker (.*);
